>>> sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round functions of the streaming MD5 unit.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_MARK,
    ST_ZERO,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_OUT
  } md5_state_t;

  typedef logic [31:0] word_t;

  // Initial chaining value A, B, C, D
  localparam word_t INIT_CV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  // Block word positions of the bit length
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;

  // Padding marker byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Last round index and last byte position in a block
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_POS   = 6'd63;

  // Round groups
  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;
  localparam logic [1:0] GRP_I = 2'd3;

  // Per-round additive constant
  function automatic word_t add_const(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotate amount, indexed by {group, round[1:0]}
  function automatic logic [4:0] rot_amt(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Block word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] g;
    lo = r[3:0];
    case (r[5:4])
      GRP_F:   g = lo;
      GRP_G:   g = 4'(lo * 4'd5 + 4'd1);
      GRP_H:   g = 4'(lo * 4'd3 + 4'd5);
      default: g = 4'(lo * 4'd7);
    endcase
    return g;
  endfunction

  function automatic word_t rotl32(input word_t x, input logic [4:0] n);
    word_t y;
    y = (x << n) | (x >> (6'd32 - {1'b0, n}));
    return y;
  endfunction

endpackage

>>> sv/md5_message_digest_unit.sv
// Throughput: one message byte per cycle while a block fills; each full
// 64-byte block then holds input for its compression (load, 64 rounds, add).
// End of message: padding writes, one or two compressions through the
// block memory with its one write and one read port, then four digest words.
// Synchronous active-low reset restores the initial chaining value and a
// zero byte count; the block memory itself is not cleared.
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// Streaming MD5: packs bytes into a 16-word block memory, runs one round per
// cycle against it, pads at end of message and returns words A, B, C, D.
// ----------------------------------------------------------------------------
module md5_message_digest_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // last_word
);
  import md5_pkg::*;

  // Block memory
  word_t      blk_mem [16];
  word_t      mem_q_r;
  logic       mem_we;
  logic [3:0] mem_waddr;
  word_t      mem_wdata;
  logic [3:0] rd_addr;

  // Control and datapath registers
  md5_state_t  state_r, state_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  word_t       acc_r, acc_nxt;
  word_t       cv_r [4];
  word_t       cv_nxt [4];
  word_t       a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [4:0]  widx_r, widx_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic        pad_r, pad_nxt;
  logic        mark_r, mark_nxt;
  logic        long_r, long_nxt;
  logic        final_r, final_nxt;

  // Round datapath
  word_t      f_val, sum, b_new, acc_byte, mark_word;
  logic [1:0] lane;
  logic [4:0] zero_limit;

  always_comb begin
    case (rnd_r[5:4])
      GRP_F:   f_val = (b_r & c_r) | (~b_r & d_r);
      GRP_G:   f_val = (b_r & d_r) | (c_r & ~d_r);
      GRP_H:   f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
    sum   = a_r + f_val + mem_q_r + add_const(rnd_r);
    b_new = b_r + rotl32(sum, rot_amt({rnd_r[5:4], rnd_r[1:0]}));
  end

  // Byte lane packing
  assign lane       = cnt_r[1:0];
  assign acc_byte   = ((lane == 2'd0) ? 32'h0 : acc_r) | ({24'h0, in_tdata} << {lane, 3'b000});
  assign mark_word  = ((lane == 2'd0) ? 32'h0 : acc_r) | ({24'h0, PAD_MARK} << {lane, 3'b000});
  assign zero_limit = long_r ? 5'd16 : 5'd14;

  // Next state and outputs
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    cv_nxt     = cv_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    rnd_nxt    = rnd_r;
    widx_nxt   = widx_r;
    oidx_nxt   = oidx_r;
    pad_nxt    = pad_r;
    mark_nxt   = mark_r;
    long_nxt   = long_r;
    final_nxt  = final_r;
    mem_we     = 1'b0;
    mem_waddr  = 4'd0;
    mem_wdata  = 32'h0;
    rd_addr    = msg_index(6'd0);
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    out_tdata  = 32'h0;
    out_tlast  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            acc_nxt = acc_byte;
            cnt_nxt = cnt_r + 61'd1;
            if (lane == 2'd3) begin
              mem_we    = 1'b1;
              mem_waddr = cnt_r[5:2];
              mem_wdata = acc_byte;
            end
          end
          if (in_tlast) pad_nxt = 1'b1;
          if (in_tuser && cnt_r[5:0] == LAST_POS) begin
            state_nxt = ST_LOAD;
          end else if (in_tlast) begin
            state_nxt = ST_MARK;
          end
        end
      end
      // Prime the read for round 0
      ST_LOAD: begin
        rd_addr   = msg_index(6'd0);
        rnd_nxt   = 6'd0;
        a_nxt     = cv_r[0];
        b_nxt     = cv_r[1];
        c_nxt     = cv_r[2];
        d_nxt     = cv_r[3];
        state_nxt = ST_ROUND;
      end
      // One round per cycle, next word fetched in parallel
      ST_ROUND: begin
        rd_addr = msg_index(rnd_r + 6'd1);
        a_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = b_r;
        b_nxt   = b_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cv_nxt[0] = cv_r[0] + a_r;
        cv_nxt[1] = cv_r[1] + b_r;
        cv_nxt[2] = cv_r[2] + c_r;
        cv_nxt[3] = cv_r[3] + d_r;
        if (final_r) begin
          oidx_nxt  = 2'd0;
          state_nxt = ST_OUT;
        end else if (pad_r && !mark_r) begin
          state_nxt = ST_MARK;
        end else if (pad_r) begin
          widx_nxt  = 5'd0;
          state_nxt = ST_ZERO;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      // Place the 0x80 marker after the last byte
      ST_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[5:2];
        mem_wdata = mark_word;
        mark_nxt  = 1'b1;
        long_nxt  = (cnt_r[5:3] == 3'b111);
        widx_nxt  = {1'b0, cnt_r[5:2]} + 5'd1;
        state_nxt = ST_ZERO;
      end
      // Zero fill up to the length words, or to block end on a long tail
      ST_ZERO: begin
        if (widx_r == zero_limit) begin
          if (long_r) begin
            long_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_LEN_LO;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = widx_r[3:0];
          mem_wdata = 32'h0;
          widx_nxt  = widx_r + 5'd1;
        end
      end
      ST_LEN_LO: begin
        mem_we    = 1'b1;
        mem_waddr = LEN_LO_WORD;
        mem_wdata = {cnt_r[28:0], 3'b000};
        state_nxt = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        mem_we    = 1'b1;
        mem_waddr = LEN_HI_WORD;
        mem_wdata = cnt_r[60:29];
        final_nxt = 1'b1;
        state_nxt = ST_LOAD;
      end
      // Digest words A..D, then back to the initial chaining value
      ST_OUT: begin
        out_tvalid = 1'b1;
        out_tdata  = cv_r[oidx_r];
        out_tlast  = (oidx_r == 2'd3);
        if (out_tready) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            cv_nxt    = INIT_CV;
            cnt_nxt   = 61'd0;
            pad_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            final_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 61'd0;
      cv_r    <= INIT_CV;
      rnd_r   <= 6'd0;
      widx_r  <= 5'd0;
      oidx_r  <= 2'd0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      long_r  <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cv_r    <= cv_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
      oidx_r  <= oidx_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      long_r  <= long_nxt;
      final_r <= final_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
  end

  // Block memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) blk_mem[mem_waddr] <= mem_wdata;
    mem_q_r <= blk_mem[rd_addr];
  end

  // Checks
  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND || state_r == ST_LOAD) |-> !mem_we)
    else $error("block memory written during compression");

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while digest pending");

  a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == LAST_ROUND) |=> (state_r == ST_ADD))
    else $error("compression did not end after last round");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (cnt_r == 61'd0 && cv_r[0] == INIT_CV[0] && !pad_r && state_r == ST_IDLE))
    else $error("state not restored after digest");

  a_digest_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (final_r && mark_r))
    else $error("digest without final padded block");

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming MD5 unit. Random and directed
// messages are sent one byte per word on the input stream. A local MD5
// model predicts the four digest words of every message, and the output
// stream is compared against them in order. Both sides idle at random
// across several phases, and the receiver stops for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  // Idle phases of the two stream sides
  typedef enum logic [1:0] {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE
  } idle_phase_t;

  // One input word plus its bench-side tags
  typedef struct packed {
    logic [7:0]  data;
    logic        bv;
    logic        eom;
    idle_phase_t phase;
    logic        hold;
  } byte_item_t;

  // One expected digest word
  typedef struct {
    word_t word;
    logic  last;
  } digest_exp_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int MIN_ITEMS = 220;
  localparam int MIN_MSGS = 8;
  localparam logic [7:0] MARK_BYTE = 8'h80;

  localparam word_t IV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  localparam word_t RND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int RND_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // Lengths that land on block and padding boundaries
  localparam int EDGE_LEN [7] = '{55, 56, 57, 63, 64, 65, 120};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  // Bench state
  byte_item_t  pending [$];
  digest_exp_t digest_q [$];
  idle_phase_t fill_phase = PH_FREE;
  logic        hold_next = 1'b0;
  idle_phase_t drv_phase = PH_FREE;
  logic        drv_hold = 1'b0;
  idle_phase_t rx_phase = PH_FREE;
  int          hold_left = 0;
  int          queued_cnt = 0;
  int          accepted_cnt = 0;
  int          errors = 0;
  int          cycle_cnt = 0;

  // MD5 model state
  word_t       chain_q [4] = IV;
  word_t       blk_q [16] = '{default: '0};
  logic [60:0] nbytes = '0;

  md5_message_digest_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  function automatic int send_idle_pct(idle_phase_t p);
    case (p)
      PH_SEND_IDLE: return 54;
      PH_BOTH_IDLE: return 9;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(idle_phase_t p);
    case (p)
      PH_RECV_STALL: return 54;
      PH_BOTH_IDLE:  return 9;
      default:       return 0;
    endcase
  endfunction

  function automatic word_t rol(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // 64 rounds over the current block, folded into the chaining value
  task automatic md5_compress();
    word_t a, b, c, d, f, t;
    int    g, grp;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int r = 0; r < 64; r++) begin
      grp = r / 16;
      case (grp)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol(a + f + blk_q[g] + RND_K[r], RND_S[grp * 4 + r % 4]);
      a = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
  endtask

  // Little-endian byte placement; the first byte of a word clears it
  task automatic place_byte(int pos, logic [7:0] v);
    int w, sh;
    w = pos / 4;
    sh = (pos % 4) * 8;
    if (pos % 4 == 0) blk_q[w] = '0;
    blk_q[w] |= word_t'(v) << sh;
  endtask

  // Take one accepted input word; an end of message yields four digest words
  task automatic absorb_item(logic [7:0] data, logic bv, logic eom);
    int          pos;
    logic [63:0] bits;
    digest_exp_t e;
    if (bv) begin
      pos = int'(nbytes[5:0]);
      place_byte(pos, data);
      nbytes = nbytes + 61'd1;
      if (pos == 63) md5_compress();
    end
    if (eom) begin
      pos = int'(nbytes[5:0]);
      place_byte(pos, MARK_BYTE);
      for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
      // no room for the length: it goes into an extra padding block
      if (pos >= 56) begin
        md5_compress();
        blk_q = '{default: '0};
      end
      bits = {nbytes, 3'b000};
      blk_q[14] = bits[31:0];
      blk_q[15] = bits[63:32];
      md5_compress();
      for (int i = 0; i < 4; i++) begin
        e.word = chain_q[i];
        e.last = (i == 3);
        digest_q.push_back(e);
      end
      chain_q = IV;
      nbytes = '0;
    end
  endtask

  task automatic flag_mismatch(string what, word_t got, word_t want);
    errors++;
    $display("mismatch: %s got %h want %h", what, got, want);
  endtask

  task automatic push_item(logic [7:0] data, logic bv, logic eom);
    byte_item_t it;
    it.data = data;
    it.bv = bv;
    it.eom = eom;
    it.phase = fill_phase;
    it.hold = hold_next;
    hold_next = 1'b0;
    pending.push_back(it);
  endtask

  // Random message; returns the number of words that carry it (noise excluded)
  task automatic queue_message(int len, bit empty_end, output int n_items);
    bit sep_end;
    sep_end = empty_end || (len == 0);
    n_items = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, (i == len - 1) && !sep_end);
      n_items++;
    end
    if (sep_end) begin
      push_item(8'($urandom), 1'b0, 1'b1);
      n_items++;
    end
  endtask

  // Driver: offer the next word once the current one is taken
  always @(posedge clk) begin : drive_in
    byte_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(pending[0].phase)) begin
        nxt = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nxt.data;
        in_tuser <= nxt.bv;
        in_tlast <= nxt.eom;
        drv_phase <= nxt.phase;
        drv_hold <= nxt.hold;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started by a tagged input word
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (in_tvalid && in_tready && drv_hold) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct(rx_phase));
    end
  end

  // Monitor: predict on input words, check output words in order
  always @(posedge clk) begin : watch
    digest_exp_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        absorb_item(in_tdata, in_tuser, in_tlast);
        accepted_cnt++;
        rx_phase <= drv_phase;
      end
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          flag_mismatch("unexpected digest word", out_tdata, '0);
        end else begin
          want = digest_q.pop_front();
          if (out_tdata !== want.word) flag_mismatch("digest_word", out_tdata, want.word);
          if (out_tlast !== want.last) flag_mismatch("last_word", word_t'(out_tlast),
                                                     word_t'(want.last));
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int msgs, msg_items, n, len;
    msgs = 0;
    msg_items = 0;

    // Directed: noise word, empty message, single bytes at the extremes,
    // the classic three-byte message, a short one with noise inside
    fill_phase = PH_FREE;
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'haa, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h5a, 1'b1, 1'b0);
    push_item(8'h55, 1'b0, 1'b1);
    queued_cnt += 13;

    // Random messages, phases change every two messages
    while (msg_items < MIN_ITEMS || msgs < MIN_MSGS) begin
      fill_phase = idle_phase_t'((msgs / 2) % 4);
      if (msgs == 5) hold_next = 1'b1;
      if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 20);
      else len = EDGE_LEN[$urandom_range(0, 6)];
      queue_message(len, 1'($urandom_range(0, 1)), n);
      msg_items += n;
      msgs++;
    end
    queued_cnt = accepted_cnt + pending.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != queued_cnt) @(negedge clk);
    while (digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
